// File: src/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the clock page replacement block
// Entry layout, command and result bundles, mode and status codes, and the
// hand wrap helper used by the engine.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_BITS = 16;

  // Slot index and count widths
  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // Fixed field widths of the ports
  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int FIU_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int ENTRY_W = PAGE_BITS + FRAME_BITS + 2;

  // Modes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOUCH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VICTIM  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_APPEND_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIU = 1'd1;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  use_b;
    logic                  mod_b;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [POS_W-1:0]      pos;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  ubit;
    logic                  mbit;
  } cmd_t;

  typedef struct packed {
    logic             enhanced;
    logic [CNT_W-1:0] n;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]      vpos;
    logic [PAGE_BITS-1:0]  vpage;
    logic [FRAME_BITS-1:0] vframe;
    logic                  vmod;
    logic [FIU_W-1:0]      fill;
    logic                  full;
    logic [STATUS_W-1:0]   status;
  } res_t;

  // Step a slot index one place, wrapping at the frame count
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = CNT_W'(idx) + CNT_W'(1);
    return (s >= n) ? '0 : IDX_W'(s);
  endfunction

endpackage

// File: src/clock_page_replacement_top.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_top: clock / enhanced second-chance frame table
// Handshake, configuration registers and output register around the engine.
// ----------------------------------------------------------------------------
// One item is taken at a time. Append, replace, clear and unknown modes go
// from transfer straight to the result; touch first reads the slot, then
// merges it. A victim request walks the slots from the hand through one
// evaluation unit fed by the single read port of the slot RAM, one slot per
// cycle: plain clock looks at most n+1 slots, enhanced clock at most 3n+1
// slots, where n is the effective frame count. A finished result waits in
// the output register while the next item is taken.
// ----------------------------------------------------------------------------
module clock_page_replacement_top (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cpr_pkg::MODE_W-1:0]        in_mode,
  input  logic [cpr_pkg::POS_W-1:0]         in_position,
  input  logic [cpr_pkg::PAGE_BITS-1:0]     in_page_number,
  input  logic [cpr_pkg::FRAME_BITS-1:0]    in_frame_number,
  input  logic                              in_use_bit,
  input  logic                              in_modified_bit,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cpr_pkg::POS_W-1:0]         out_victim_position,
  output logic [cpr_pkg::PAGE_BITS-1:0]     out_victim_page,
  output logic [cpr_pkg::FRAME_BITS-1:0]    out_victim_frame,
  output logic                              out_victim_modified,
  output logic [cpr_pkg::FIU_W-1:0]         out_filled_count,
  output logic                              out_table_full,
  output logic [cpr_pkg::STATUS_W-1:0]      out_status,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpr_pkg::FIU_W-1:0]         cfg_data
);

  logic                      alg_r;
  logic [cpr_pkg::FIU_W-1:0] fiu_r;
  cpr_pkg::cfg_t             cfg;
  cpr_pkg::cmd_t             cmd;
  cpr_pkg::res_t             res;
  cpr_pkg::res_t             out_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      eng_ready;
  logic                      eng_res_valid;
  logic                      res_take;
  logic                      start;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= 1'b0;
      fiu_r <= cpr_pkg::FIU_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpr_pkg::CFG_ALG: alg_r <= cfg_data[0];
        cpr_pkg::CFG_FIU: fiu_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective frame count: zero acts as one, clamp at table size
  always_comb begin
    cfg.enhanced = alg_r;
    if (fiu_r == '0) begin
      cfg.n = cpr_pkg::CNT_W'(1);
    end else if (int'(fiu_r) > cpr_pkg::MAX_FRAMES) begin
      cfg.n = cpr_pkg::CNT_W'(cpr_pkg::MAX_FRAMES);
    end else begin
      cfg.n = cpr_pkg::CNT_W'(fiu_r);
    end
  end

  // Input transfer
  assign in_stall = !eng_ready;
  assign start    = in_valid && !in_stall;

  always_comb begin
    cmd.mode  = in_mode;
    cmd.pos   = in_position;
    cmd.page  = in_page_number;
    cmd.frame = in_frame_number;
    cmd.ubit  = in_use_bit;
    cmd.mbit  = in_modified_bit;
  end

  cpr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .ready     (eng_ready),
    .res_valid (eng_res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_take = eng_res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_victim_position = out_r.vpos;
  assign out_victim_page     = out_r.vpage;
  assign out_victim_frame    = out_r.vframe;
  assign out_victim_modified = out_r.vmod;
  assign out_filled_count    = out_r.fill;
  assign out_table_full      = out_r.full;
  assign out_status          = out_r.status;

endmodule

// File: src/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram: generic simple dual port RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cpr_engine.sv
// ----------------------------------------------------------------------------
// cpr_engine: frame table sequencer
// Holds the slot RAM, the per-slot valid bits, the hand and the fill count,
// and sequences each command; victim scans run through one slot evaluation unit, one slot a cycle.
// ----------------------------------------------------------------------------
module cpr_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cpr_pkg::cmd_t cmd,
  input  cpr_pkg::cfg_t cfg,
  output logic          ready,
  output logic          res_valid,
  input  logic          res_take,
  output cpr_pkg::res_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TOUCH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [cpr_pkg::CNT_W-1:0]      fill_r, fill_nxt;
  logic [cpr_pkg::IDX_W-1:0]      hand_r, hand_nxt;
  logic [cpr_pkg::MAX_FRAMES-1:0] vld_r, vld_nxt;

  // Scan pipeline: read pointer, evaluation stage, bypass of a same-cycle write
  logic [cpr_pkg::IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                      ev_v_r, ev_v_nxt;
  logic [cpr_pkg::IDX_W-1:0] ev_addr_r, ev_addr_nxt;
  logic                      ev_vld_r, ev_vld_nxt;
  logic                      byp_r, byp_nxt;
  cpr_pkg::entry_t           byp_ent_r, byp_ent_nxt;
  logic [cpr_pkg::IDX_W-1:0] step_r, step_nxt;
  logic                      pass_r, pass_nxt;

  // Command held for multi-cycle modes
  logic                      mbit_r, mbit_nxt;

  // Result fields
  logic [cpr_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [cpr_pkg::IDX_W-1:0]      vpos_r, vpos_nxt;
  logic [cpr_pkg::PAGE_BITS-1:0]  vpage_r, vpage_nxt;
  logic [cpr_pkg::FRAME_BITS-1:0] vframe_r, vframe_nxt;
  logic                           vmod_r, vmod_nxt;

  // RAM ports
  logic                         we;
  logic [cpr_pkg::IDX_W-1:0]    waddr;
  cpr_pkg::entry_t              wdata;
  logic [cpr_pkg::IDX_W-1:0]    raddr;
  logic [cpr_pkg::ENTRY_W-1:0]  rdata;

  // Decode helpers
  logic                      pos_bad;
  logic [cpr_pkg::IDX_W-1:0] pos_idx;
  logic [cpr_pkg::IDX_W-1:0] hand_eff;
  cpr_pkg::entry_t           ram_ent;
  cpr_pkg::entry_t           ent;
  logic                      hit;
  logic                      clr_use;

  cpr_ram #(
    .WIDTH (cpr_pkg::ENTRY_W),
    .DEPTH (cpr_pkg::MAX_FRAMES)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_bad = (cpr_pkg::CMP_W'(cmd.pos) >= cpr_pkg::CMP_W'(fill_r)) ||
                   (cpr_pkg::CMP_W'(cmd.pos) >= cpr_pkg::CMP_W'(cpr_pkg::MAX_FRAMES));
  assign pos_idx  = cpr_pkg::IDX_W'(cmd.pos);
  assign hand_eff = (cpr_pkg::CNT_W'(hand_r) >= cfg.n) ? '0 : hand_r;

  // Effective slot contents: bypass wins, an invalid slot has use and modified clear
  always_comb begin
    ram_ent = cpr_pkg::entry_t'(rdata);
    if (byp_r) begin
      ent = byp_ent_r;
    end else begin
      ent = ram_ent;
      if (!ev_vld_r) begin
        ent.use_b = 1'b0;
        ent.mod_b = 1'b0;
      end
    end
  end

  // Slot evaluation unit
  always_comb begin
    if (!cfg.enhanced) begin
      hit = !ent.use_b;
    end else if (!pass_r) begin
      hit = !ent.use_b && !ent.mod_b;
    end else begin
      hit = !ent.use_b && ent.mod_b;
    end
    clr_use = ent.use_b && (!cfg.enhanced || pass_r);
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    hand_nxt    = hand_r;
    vld_nxt     = vld_r;
    rd_ptr_nxt  = rd_ptr_r;
    ev_v_nxt    = 1'b0;
    ev_addr_nxt = ev_addr_r;
    ev_vld_nxt  = ev_vld_r;
    byp_nxt     = 1'b0;
    byp_ent_nxt = byp_ent_r;
    step_nxt    = step_r;
    pass_nxt    = pass_r;
    mbit_nxt    = mbit_r;
    status_nxt  = status_r;
    vpos_nxt    = vpos_r;
    vpage_nxt   = vpage_r;
    vframe_nxt  = vframe_r;
    vmod_nxt    = vmod_r;
    we          = 1'b0;
    waddr       = pos_idx;
    wdata       = '0;
    raddr       = pos_idx;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = cpr_pkg::ST_OK;
          vpos_nxt   = '0;
          vpage_nxt  = '0;
          vframe_nxt = '0;
          vmod_nxt   = 1'b0;
          mbit_nxt   = cmd.mbit;
          state_nxt  = S_DONE;
          case (cmd.mode)
            cpr_pkg::MODE_APPEND: begin
              if (fill_r >= cfg.n) begin
                status_nxt = cpr_pkg::ST_APPEND_FULL;
              end else begin
                we          = 1'b1;
                waddr       = cpr_pkg::IDX_W'(fill_r);
                wdata.page  = cmd.page;
                wdata.frame = cmd.frame;
                wdata.use_b = cmd.ubit;
                wdata.mod_b = cmd.mbit;
                vld_nxt[cpr_pkg::IDX_W'(fill_r)] = 1'b1;
                fill_nxt    = cpr_pkg::CNT_W'(fill_r + cpr_pkg::CNT_W'(1));
              end
            end
            cpr_pkg::MODE_REPLACE: begin
              if (pos_bad) begin
                status_nxt = cpr_pkg::ST_BAD_POS;
              end else begin
                we          = 1'b1;
                wdata.page  = cmd.page;
                wdata.frame = cmd.frame;
                wdata.use_b = cmd.ubit;
                wdata.mod_b = cmd.mbit;
                vld_nxt[pos_idx] = 1'b1;
              end
            end
            cpr_pkg::MODE_TOUCH: begin
              if (pos_bad) begin
                status_nxt = cpr_pkg::ST_BAD_POS;
              end else begin
                // read the slot now, merge next cycle
                ev_addr_nxt = pos_idx;
                ev_vld_nxt  = vld_r[pos_idx];
                state_nxt   = S_TOUCH;
              end
            end
            cpr_pkg::MODE_VICTIM: begin
              if (fill_r < cfg.n) begin
                status_nxt = cpr_pkg::ST_NOT_FULL;
              end else begin
                rd_ptr_nxt = hand_eff;
                hand_nxt   = hand_eff;
                step_nxt   = '0;
                pass_nxt   = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            cpr_pkg::MODE_CLEAR: begin
              fill_nxt = '0;
              hand_nxt = '0;
              vld_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_TOUCH: begin
        // set use, fold in the write flag
        we          = 1'b1;
        waddr       = ev_addr_r;
        wdata.page  = ent.page;
        wdata.frame = ent.frame;
        wdata.use_b = 1'b1;
        wdata.mod_b = ent.mod_b | mbit_r;
        vld_nxt[ev_addr_r] = 1'b1;
        state_nxt   = S_DONE;
      end

      S_SCAN: begin
        if (ev_v_r) begin
          hand_nxt = cpr_pkg::wrap_inc(ev_addr_r, cfg.n);
          if (cpr_pkg::CNT_W'(step_r) + cpr_pkg::CNT_W'(1) >= cfg.n) begin
            step_nxt = '0;
            pass_nxt = !pass_r;
          end else begin
            step_nxt = cpr_pkg::IDX_W'(cpr_pkg::CNT_W'(step_r) + cpr_pkg::CNT_W'(1));
          end
          if (clr_use) begin
            we          = 1'b1;
            waddr       = ev_addr_r;
            wdata.page  = ent.page;
            wdata.frame = ent.frame;
            wdata.use_b = 1'b0;
            wdata.mod_b = ent.mod_b;
            vld_nxt[ev_addr_r] = 1'b1;
          end
        end
        if (ev_v_r && hit) begin
          vpos_nxt   = ev_addr_r;
          vpage_nxt  = ent.page;
          vframe_nxt = ent.frame;
          vmod_nxt   = ent.mod_b;
          state_nxt  = S_DONE;
        end else begin
          // issue the next slot read, forwarding a write to the same slot
          raddr       = rd_ptr_r;
          rd_ptr_nxt  = cpr_pkg::wrap_inc(rd_ptr_r, cfg.n);
          ev_v_nxt    = 1'b1;
          ev_addr_nxt = rd_ptr_r;
          byp_nxt     = we && (waddr == rd_ptr_r);
          byp_ent_nxt = wdata;
          ev_vld_nxt  = vld_r[rd_ptr_r] | byp_nxt;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      hand_r  <= '0;
      vld_r   <= '0;
      ev_v_r  <= 1'b0;
      byp_r   <= 1'b0;
      step_r  <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      hand_r  <= hand_nxt;
      vld_r   <= vld_nxt;
      ev_v_r  <= ev_v_nxt;
      byp_r   <= byp_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    ev_addr_r <= ev_addr_nxt;
    ev_vld_r  <= ev_vld_nxt;
    byp_ent_r <= byp_ent_nxt;
    mbit_r    <= mbit_nxt;
    status_r  <= status_nxt;
    vpos_r    <= vpos_nxt;
    vpage_r   <= vpage_nxt;
    vframe_r  <= vframe_nxt;
    vmod_r    <= vmod_nxt;
  end

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.vpos   = cpr_pkg::POS_W'(vpos_r);
    res.vpage  = vpage_r;
    res.vframe = vframe_r;
    res.vmod   = vmod_r;
    res.fill   = cpr_pkg::FIU_W'(fill_r);
    res.full   = (fill_r >= cfg.n);
    res.status = status_r;
  end

endmodule
